FILE: rtl/core/overcurrent_trip_channel_defines.svh
// assertion macros shared by the overcurrent trip channel rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef OVERCURRENT_TRIP_CHANNEL_DEFINES_SVH
`define OVERCURRENT_TRIP_CHANNEL_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define OTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define OTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// invariant checked every cycle out of reset
`define OTC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) 1'b1 |-> (cond)) \
    else $error(msg);

`endif

FILE: rtl/core/otc_pkg.sv
// shared types and constants of the overcurrent trip channel
// no dependencies
package otc_pkg;

  localparam int unsigned CUR_W     = 16;
  localparam int unsigned THR_W     = 15;
  localparam int unsigned SHUNT_W   = 10;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned AVG_W     = 16;
  localparam int unsigned MAG_W     = AVG_W + 1;
  localparam int unsigned PROD_W    = MAG_W + SHUNT_W;
  localparam int unsigned RECIP_W   = 26;
  localparam int unsigned RECIP_SH  = 35;
  localparam int unsigned EST_W     = PROD_W + RECIP_W - RECIP_SH;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 4;

  // floor(2^35 / 1000), quotient estimate is exact or one low
  localparam logic [RECIP_W-1:0] RECIP_M = 26'd34359738;
  localparam logic [PROD_W-1:0]  MV_DIV  = 27'd1000;

  localparam logic [THR_W-1:0]   THR_RST     = 15'd10000;
  localparam logic [SHUNT_W-1:0] SHUNT_RST   = 10'd10;
  localparam logic [TIME_W-1:0]  HOLDOFF_RST = 32'd5000;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_GATE   = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_TICK   = 3'd3,
    OP_STATUS = 3'd4
  } otc_op_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SHUNT     = 2'd1,
    REG_HOLDOFF   = 2'd2
  } otc_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SETUP,
    ST_DIVIDE,
    ST_MUL,
    ST_RECIP,
    ST_FINISH
  } otc_state_e;

  typedef struct packed {
    logic [THR_W-1:0]   thr;
    logic [SHUNT_W-1:0] shunt;
    logic [TIME_W-1:0]  holdoff;
  } otc_cfg_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_init;
    logic div_step;
    logic mul;
    logic recip;
    logic finish;
  } otc_cmd_t;

  typedef struct packed {
    logic out_free;
  } otc_stat_t;

endpackage

FILE: rtl/core/otc_regs.sv
// apb-style configuration registers of the overcurrent trip channel
// depends on otc_pkg
module otc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [otc_pkg::ADDR_W-1:0]   paddr,
  input  logic [otc_pkg::DATA_W-1:0]   pwdata,
  output logic [otc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output otc_pkg::otc_cfg_t            cfg_o
);
  import otc_pkg::*;

  otc_cfg_t cfg_q, cfg_d;
  otc_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = otc_reg_e'(paddr[ADDR_W-1:2]);
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_THRESHOLD: cfg_d.thr     = pwdata[THR_W-1:0];
        REG_SHUNT:     cfg_d.shunt   = pwdata[SHUNT_W-1:0];
        REG_HOLDOFF:   cfg_d.holdoff = pwdata[TIME_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_THRESHOLD: prdata = DATA_W'(cfg_q.thr);
      REG_SHUNT:     prdata = DATA_W'(cfg_q.shunt);
      REG_HOLDOFF:   prdata = DATA_W'(cfg_q.holdoff);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr     <= THR_RST;
      cfg_q.shunt   <= SHUNT_RST;
      cfg_q.holdoff <= HOLDOFF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/core/otc_ctrl.sv
// sequencing state machine of the overcurrent trip channel
// depends on otc_pkg and the assertion macro header
`include "overcurrent_trip_channel_defines.svh"

module otc_ctrl #(
  parameter int unsigned ITER = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  otc_pkg::otc_stat_t  stat_i,
  output otc_pkg::otc_cmd_t   cmd_o
);
  import otc_pkg::*;

  localparam int unsigned ITER_W = $clog2(ITER + 1);

  otc_state_e        state_q, state_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_SETUP;
      ST_SETUP: begin
        cnt_d   = ITER_W'(ITER);
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cnt_d = cnt_q - ITER_W'(1);
        if (cnt_q == ITER_W'(1)) state_d = ST_MUL;
      end
      ST_MUL:    state_d = ST_RECIP;
      ST_RECIP:  state_d = ST_FINISH;
      ST_FINISH: if (stat_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_UPDATE: cmd_o.update   = 1'b1;
      ST_SETUP:  cmd_o.div_init = 1'b1;
      ST_DIVIDE: cmd_o.div_step = 1'b1;
      ST_MUL:    cmd_o.mul      = 1'b1;
      ST_RECIP:  cmd_o.recip    = 1'b1;
      ST_FINISH: cmd_o.finish   = stat_i.out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `OTC_ASSERT_NEXT(a_finish_to_idle, cmd_o.finish, in_ready_o, "no return to idle after result")
  `OTC_ASSERT_NEXT(a_capture_update, cmd_o.capture, cmd_o.update, "capture not followed by update")

endmodule

FILE: rtl/core/otc_dp.sv
// datapath of the overcurrent trip channel: channel state, bit-serial divider,
// millivolt scaling and output register; depends on otc_pkg and the macro header
`include "overcurrent_trip_channel_defines.svh"

module otc_dp #(
  parameter int unsigned WINDOW = 10,
  parameter int unsigned CNT_W  = 4,
  parameter int unsigned SUM_W  = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  otc_pkg::otc_cmd_t                   cmd_i,
  output otc_pkg::otc_stat_t                  stat_o,
  input  otc_pkg::otc_cfg_t                   cfg_i,
  input  logic [2:0]                          operation_i,
  input  logic signed [otc_pkg::CUR_W-1:0]    current_ma_i,
  input  logic                                gate_request_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                gate_on_o,
  output logic                                fault_latched_o,
  output logic                                rejected_o,
  output logic signed [otc_pkg::AVG_W-1:0]    avg_current_ma_o,
  output logic signed [otc_pkg::AVG_W-1:0]    drop_mv_o,
  output logic [otc_pkg::TIME_W-1:0]          trip_time_ms_o
);
  import otc_pkg::*;

  localparam int unsigned       LIM_W  = SUM_W - 1;
  localparam logic [CNT_W-1:0]  WIN_C  = CNT_W'(WINDOW);
  localparam logic [MAG_W-1:0]  POS_LIM = MAG_W'(32767);
  localparam logic [MAG_W-1:0]  NEG_LIM = MAG_W'(32768);
  localparam logic [EST_W-1:0]  POS_SAT = EST_W'(32767);
  localparam logic [EST_W-1:0]  NEG_SAT = EST_W'(32768);

  // captured item
  logic [2:0]              op_q;
  logic signed [CUR_W-1:0] cur_q;
  logic                    req_q;

  // channel state
  logic [TIME_W-1:0]       now_q, now_d, trip_q, trip_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic                    gate_q, gate_d, fault_q, fault_d, rej_q, rej_d;

  // divider and scaling
  logic                    sign_q;
  logic [SUM_W-1:0]        quo_q;
  logic [CNT_W-1:0]        rem_q, dvs_q;
  logic signed [AVG_W-1:0] avg_q;
  logic [PROD_W-1:0]       prod_q;
  logic [EST_W-1:0]        est_q;

  // output register
  logic                    out_valid_q;
  logic                    out_gate_q, out_fault_q, out_rej_q;
  logic signed [AVG_W-1:0] out_avg_q, out_drop_q;
  logic [TIME_W-1:0]       out_trip_q;

  logic signed [SUM_W-1:0]        sum_inc;
  logic [CNT_W-1:0]               idx_inc;
  logic [LIM_W-1:0]               lim;
  logic                           over;
  logic [TIME_W-1:0]              elapsed;
  logic                           clear_ok;
  logic [SUM_W-1:0]               sum_mag;
  logic [CNT_W:0]                 rem_sh, rem_sub;
  logic                           rem_ge;
  logic [MAG_W-1:0]               mag_lim, mag_avg;
  logic [PROD_W+RECIP_W-1:0]      recip_full;
  logic [PROD_W-1:0]              est_rem;
  logic [EST_W-1:0]               est_adj;
  logic signed [AVG_W-1:0]        drop_val;

  // state update
  assign sum_inc  = sum_q + $signed({{(SUM_W-CUR_W){cur_q[CUR_W-1]}}, cur_q});
  assign idx_inc  = idx_q + CNT_W'(1);
  assign lim      = LIM_W'(cfg_i.thr) * LIM_W'(WINDOW);
  assign over     = !sum_inc[SUM_W-1] && (sum_inc[LIM_W-1:0] > lim);
  assign elapsed  = now_q - trip_q;
  assign clear_ok = elapsed > cfg_i.holdoff;

  always_comb begin
    now_d   = now_q;
    sum_d   = sum_q;
    idx_d   = idx_q;
    gate_d  = gate_q;
    fault_d = fault_q;
    trip_d  = trip_q;
    rej_d   = rej_q;
    if (cmd_i.update) begin
      rej_d = 1'b0;
      unique case (op_q)
        OP_SAMPLE: begin
          if (fault_q) begin
            gate_d = 1'b0;
            rej_d  = 1'b1;
          end else if (idx_inc == WIN_C) begin
            if (over) begin
              gate_d  = 1'b0;
              fault_d = 1'b1;
              trip_d  = now_q;
            end
            sum_d = '0;
            idx_d = '0;
          end else begin
            sum_d = sum_inc;
            idx_d = idx_inc;
          end
        end
        OP_GATE: begin
          if (fault_q) rej_d = 1'b1;
          else gate_d = req_q;
        end
        OP_CLEAR: begin
          if (clear_ok) begin
            fault_d = 1'b0;
            sum_d   = '0;
            idx_d   = '0;
          end else begin
            rej_d = 1'b1;
          end
        end
        OP_TICK: now_d = now_q + TIME_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      sum_q   <= '0;
      idx_q   <= '0;
      gate_q  <= 1'b0;
      fault_q <= 1'b0;
      trip_q  <= '0;
      rej_q   <= 1'b0;
    end else begin
      now_q   <= now_d;
      sum_q   <= sum_d;
      idx_q   <= idx_d;
      gate_q  <= gate_d;
      fault_q <= fault_d;
      trip_q  <= trip_d;
      rej_q   <= rej_d;
    end
  end

  // restoring divider, one quotient bit a cycle
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  // average clamp and shunt product
  assign mag_lim = sign_q ? NEG_LIM : POS_LIM;
  assign mag_avg = (quo_q > SUM_W'(mag_lim)) ? mag_lim : quo_q[MAG_W-1:0];

  // divide by 1000 via reciprocal, one correction step
  assign recip_full = (PROD_W+RECIP_W)'(prod_q) * (PROD_W+RECIP_W)'(RECIP_M);
  assign est_rem    = prod_q - PROD_W'(est_q) * MV_DIV;
  assign est_adj    = (est_rem >= MV_DIV) ? (est_q + EST_W'(1)) : est_q;

  always_comb begin
    if (sign_q) begin
      if (est_adj > NEG_SAT) drop_val = AVG_W'(NEG_SAT);
      else drop_val = AVG_W'(EST_W'(0) - est_adj);
    end else begin
      if (est_adj > POS_SAT) drop_val = AVG_W'(POS_SAT);
      else drop_val = AVG_W'(est_adj);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      cur_q <= current_ma_i;
      req_q <= gate_request_i;
    end
    if (cmd_i.div_init) begin
      sign_q <= sum_q[SUM_W-1];
      quo_q  <= sum_mag;
      rem_q  <= '0;
      dvs_q  <= (idx_q == '0) ? CNT_W'(1) : idx_q;
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], rem_ge};
      rem_q <= rem_sub[CNT_W-1:0];
    end
    if (cmd_i.mul) begin
      avg_q  <= AVG_W'(sign_q ? (MAG_W'(0) - mag_avg) : mag_avg);
      prod_q <= PROD_W'(mag_avg) * PROD_W'(cfg_i.shunt);
    end
    if (cmd_i.recip) begin
      est_q <= recip_full[PROD_W+RECIP_W-1:RECIP_SH];
    end
    if (cmd_i.finish) begin
      out_gate_q  <= gate_q;
      out_fault_q <= fault_q;
      out_rej_q   <= rej_q;
      out_avg_q   <= avg_q;
      out_drop_q  <= drop_val;
      out_trip_q  <= trip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign gate_on_o        = out_gate_q;
  assign fault_latched_o  = out_fault_q;
  assign rejected_o       = out_rej_q;
  assign avg_current_ma_o = out_avg_q;
  assign drop_mv_o        = out_drop_q;
  assign trip_time_ms_o   = out_trip_q;

  `OTC_ASSERT_ALWAYS(a_fault_gate_off, !(fault_q && gate_q), "gate on while fault latched")
  `OTC_ASSERT_ALWAYS(a_idx_in_window, idx_q < WIN_C, "sample count reached window")
  `OTC_ASSERT_IMPL(a_empty_block_zero, idx_q == '0, sum_q == '0, "sum left with empty block")
  `OTC_ASSERT_IMPL(a_no_overwrite, cmd_i.finish, !out_valid_q || out_ready_i, "result overwritten")

endmodule

FILE: rtl/core/overcurrent_trip_channel.sv
// channel   direction  signals                                  transfer when
// in        input      in_valid_i/in_ready_o, operation_i ...   valid and ready high
// out       output     out_valid_o/out_ready_i, gate_on_o ...   valid and ready high
// cfg       input      psel/penable/pwrite/paddr/pwdata/prdata  psel, penable, pwrite
//
// one item at a time: each passes the update, setup, divide, multiply, reciprocal
// and finish steps before its result is registered; the divide step is the
// restoring divider taking one quotient bit a cycle
// the next item is taken as soon as the result sits in the output register
// a stalled output holds the channel in its final step until the register frees
// reset is asynchronous active low and restores register defaults and zero state
//
// top level of the overcurrent trip channel
// depends on otc_pkg, otc_regs, otc_ctrl and otc_dp
module overcurrent_trip_channel #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          operation_i,
  input  logic signed [otc_pkg::CUR_W-1:0]    current_ma_i,
  input  logic                                gate_request_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                gate_on_o,
  output logic                                fault_latched_o,
  output logic                                rejected_o,
  output logic signed [otc_pkg::AVG_W-1:0]    avg_current_ma_o,
  output logic signed [otc_pkg::AVG_W-1:0]    drop_mv_o,
  output logic [otc_pkg::TIME_W-1:0]          trip_time_ms_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [otc_pkg::ADDR_W-1:0]          paddr,
  input  logic [otc_pkg::DATA_W-1:0]          pwdata,
  output logic [otc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);
  import otc_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = CUR_W + CNT_W;

  otc_cfg_t  cfg;
  otc_cmd_t  cmd;
  otc_stat_t stat;

  otc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  otc_ctrl #(
    .ITER (SUM_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  otc_dp #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W),
    .SUM_W  (SUM_W)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_i            (cfg),
    .operation_i      (operation_i),
    .current_ma_i     (current_ma_i),
    .gate_request_i   (gate_request_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .gate_on_o        (gate_on_o),
    .fault_latched_o  (fault_latched_o),
    .rejected_o       (rejected_o),
    .avg_current_ma_o (avg_current_ma_o),
    .drop_mv_o        (drop_mv_o),
    .trip_time_ms_o   (trip_time_ms_o)
  );

endmodule
